// ----- hdl/blop_pkg.sv -----
// Shared constants, types and fixed-point helpers of the binomial lattice pricer.
package blop_pkg;

   localparam int STEP_W      = 11;  // step count register
   localparam int PRICE_W     = 32;  // unsigned Q16.16 prices
   localparam int FACTOR_W    = 32;  // Q2.30 up factor squared
   localparam int COEF_W      = 31;  // Q1.30 / Q0.30 coefficients below 2.0, up probability clamped to 1.0
   localparam int PROD_W      = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_STEPS_DEF = 1024;

   // Overlap threshold of the node pipeline: a pass of this many nodes
   // or fewer must drain before the next one starts reading.
   localparam int PIPE_GAP = 5;

   localparam logic [COEF_W-1:0]  Q30_ONE  = 31'h4000_0000;
   localparam logic [PROD_W-1:0]  Q30_HALF = 64'h0000_0000_2000_0000;
   localparam logic [PRICE_W-1:0] SAT_VAL  = 32'hFFFF_FFFF;

   // reset values of the registers
   localparam logic [STEP_W-1:0]   STEP_COUNT_RST = 11'd1;
   localparam logic [FACTOR_W-1:0] UP_SQ_RST      = 32'h4000_0000;
   localparam logic [COEF_W-1:0]   LOW_LEAF_RST   = 31'h4000_0000;
   localparam logic [COEF_W-1:0]   UP_PROB_RST    = 31'h2000_0000;
   localparam logic [COEF_W-1:0]   DISCOUNT_RST   = 31'h4000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEP_COUNT    = 3'd0,
      CSR_UP_SQUARED    = 3'd1,
      CSR_LOWEST_LEAF   = 3'd2,
      CSR_UP_PROB       = 3'd3,
      CSR_STEP_DISCOUNT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic start;      // request taken: latch operands, clear flag
      logic leaf_mul;   // leaf price and next multiplier products
      logic leaf_more;  // another leaf follows, advance the multiplier
      logic ind_rd;     // induction read of one node
      logic finish;     // load the result register
   } cmd_type;

   typedef struct packed {
      logic busy;       // node pipeline still holds work
   } sts_type;

   // Q2.30 product rounding: (prod + 2^29) >> 30, saturated to 32 bits.
   // Returns {saturated, value}.
   function automatic logic [PRICE_W:0] q30_round(input logic [PROD_W-1:0] prod);
      logic [PROD_W:0] sum;
      sum = {1'b0, prod} + {1'b0, Q30_HALF};
      if (|sum[PROD_W:62]) begin
         return {1'b1, SAT_VAL};
      end
      return {1'b0, sum[61:30]};
   endfunction

endpackage

// ----- hdl/blop_if.sv -----
// Request and response channel interfaces of the binomial lattice pricer.
interface blop_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] spot_price;
   logic [31:0] strike;
   logic        is_put;

   modport source (output valid, output spot_price, output strike, output is_put,
                   input ready);
   modport sink   (input valid, input spot_price, input strike, input is_put,
                   output ready);
endinterface

interface blop_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] option_price;
   logic        saturated;

   modport source (output valid, output option_price, output saturated,
                    input ready);
   modport sink   (input valid, input option_price, input saturated,
                   output ready);
endinterface

// ----- hdl/blop_ctrl.sv -----
// Sequencer of the binomial lattice pricer: leaf build, induction passes, result.
module blop_ctrl #(
   parameter int MAX_STEPS = blop_pkg::MAX_STEPS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [blop_pkg::STEP_W-1:0] step_count,
   output blop_pkg::cmd_type           cmd,
   output logic [$clog2(MAX_STEPS+1)-1:0] cmd_addr,
   input  blop_pkg::sts_type           sts
);

   localparam int AW = $clog2(MAX_STEPS + 1);
   localparam int CW = (AW > blop_pkg::STEP_W) ? AW : blop_pkg::STEP_W;

   typedef enum logic [2:0] {
      IDLE, LEAF_MUL, LEAF_WR, IND, DRAIN, FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   n_ff, n_in;
   logic [AW-1:0]   idx_ff, idx_in;
   logic [AW-1:0]   s_ff, s_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]   sc_ext;
   logic            out_free;

   assign sc_ext   = CW'(step_count);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd           = '0;
      cmd.start     = (state_ff == IDLE) && req_valid;
      cmd.leaf_mul  = (state_ff == LEAF_MUL);
      cmd.leaf_more = (idx_ff != n_ff);
      cmd.ind_rd    = (state_ff == IND);
      cmd.finish    = (state_ff == FINISH) && out_free;
   end

   assign cmd_addr  = idx_ff;
   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               n_in     = (sc_ext > CW'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(sc_ext);
               idx_in   = '0;
               state_in = LEAF_MUL;
            end
         end
         LEAF_MUL: begin
            state_in = LEAF_WR;
         end
         LEAF_WR: begin
            if (idx_ff == n_ff) begin
               idx_in   = '0;
               s_in     = n_ff;
               state_in = (n_ff == '0) ? FINISH : IND;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = LEAF_MUL;
            end
         end
         IND: begin
            if (idx_ff == s_ff) begin
               idx_in   = '0;
               s_in     = s_ff - 1'b1;
               // long passes overlap: the next pass reads behind the writes
               state_in = (32'(s_ff) > 32'(blop_pkg::PIPE_GAP)) ? IND : DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         DRAIN: begin
            if (!sts.busy) begin
               state_in = (s_ff == '0) ? FINISH : IND;
            end
         end
         FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         n_ff         <= '0;
         idx_ff       <= '0;
         s_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         s_ff         <= s_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/blop_dp.sv -----
// Datapath of the binomial lattice pricer: node memory, shared multipliers, rounding.
module blop_dp #(
   parameter int MAX_STEPS = blop_pkg::MAX_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  blop_pkg::cmd_type             cmd,
   input  logic [$clog2(MAX_STEPS+1)-1:0] cmd_addr,
   output blop_pkg::sts_type             sts,
   input  logic [blop_pkg::PRICE_W-1:0]  spot_price,
   input  logic [blop_pkg::PRICE_W-1:0]  strike,
   input  logic                          is_put,
   input  logic [blop_pkg::FACTOR_W-1:0] up_factor_squared,
   input  logic [blop_pkg::COEF_W-1:0]   lowest_leaf_factor,
   input  logic [blop_pkg::COEF_W-1:0]   up_probability,
   input  logic [blop_pkg::COEF_W-1:0]   step_discount,
   output logic [blop_pkg::PRICE_W-1:0]  option_price,
   output logic                          saturated
);

   localparam int AW    = $clog2(MAX_STEPS + 1);
   localparam int DEPTH = MAX_STEPS + 1;
   localparam int PW    = blop_pkg::PRICE_W;
   localparam int CF    = blop_pkg::COEF_W;
   localparam int XW    = blop_pkg::PROD_W;

   logic [PW-1:0] node_mem [DEPTH];

   // request operands
   logic [PW-1:0] spot_ff, strike_ff;
   logic          put_ff;
   logic [CF-1:0] p_ff, q_ff, p_in;
   logic [PW-1:0] m_ff;
   logic          ovf_ff, ovf_in;

   // node pipeline
   logic [PW-1:0] rd_ff, prev_ff;
   logic          s1_rd_ff, s1_cmp_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [XW-1:0] prod_a_ff, prod_b_ff, prod_d_ff;
   logic          lv_ff, l_more_ff, s2_cmp_ff, s3_cmp_ff, s4_cmp_ff;
   logic [AW-1:0] addr2_ff, s3_addr_ff, s4_addr_ff;
   logic [PW-1:0] mean_ff;
   logic [PW-1:0] res_ff, out_price_ff;
   logic          out_sat_ff;

   logic [PW-1:0] mul_a_x, mul_a_y, mul_b_x, mul_b_y;
   logic [XW-1:0] acc;
   logic [PW:0]   price_r, m_r, node_r;
   logic [PW-1:0] pay;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [PW-1:0] wr_data;

   assign p_in = (up_probability > blop_pkg::Q30_ONE) ? blop_pkg::Q30_ONE : up_probability;

   // shared multipliers: leaf products or the two weighted node terms
   always_comb begin
      if (cmd.leaf_mul) begin
         mul_a_x = m_ff;
         mul_a_y = up_factor_squared;
         mul_b_x = spot_ff;
         mul_b_y = m_ff;
      end else begin
         mul_a_x = PW'(p_ff);
         mul_a_y = rd_ff;
         mul_b_x = PW'(q_ff);
         mul_b_y = prev_ff;
      end
   end

   assign acc     = prod_a_ff + prod_b_ff + blop_pkg::Q30_HALF;
   assign price_r = blop_pkg::q30_round(prod_b_ff);
   assign m_r     = blop_pkg::q30_round(prod_a_ff);
   assign node_r  = blop_pkg::q30_round(prod_d_ff);

   always_comb begin
      if (put_ff) begin
         pay = (strike_ff > price_r[PW-1:0]) ? strike_ff - price_r[PW-1:0] : '0;
      end else begin
         pay = (price_r[PW-1:0] > strike_ff) ? price_r[PW-1:0] - strike_ff : '0;
      end
   end

   assign wr_en   = lv_ff || s4_cmp_ff;
   assign wr_addr = lv_ff ? addr2_ff : s4_addr_ff;
   assign wr_data = lv_ff ? pay : node_r[PW-1:0];

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.start) begin
         ovf_in = 1'b0;
      end else begin
         if (lv_ff && (price_r[PW] || (l_more_ff && m_r[PW]))) begin
            ovf_in = 1'b1;
         end
         if (s4_cmp_ff && node_r[PW]) begin
            ovf_in = 1'b1;
         end
      end
   end

   assign sts.busy = s1_rd_ff || s2_cmp_ff || s3_cmp_ff || s4_cmp_ff || lv_ff;

   // node memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.ind_rd) begin
         rd_ff <= node_mem[cmd_addr];
      end
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
   end

   // control bits of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_rd_ff  <= 1'b0;
         s1_cmp_ff <= 1'b0;
         s2_cmp_ff <= 1'b0;
         s3_cmp_ff <= 1'b0;
         s4_cmp_ff <= 1'b0;
         lv_ff     <= 1'b0;
         l_more_ff <= 1'b0;
         ovf_ff    <= 1'b0;
         m_ff      <= '0;
      end else begin
         s1_rd_ff  <= cmd.ind_rd;
         s1_cmp_ff <= cmd.ind_rd && (cmd_addr != '0);
         s2_cmp_ff <= s1_cmp_ff;
         s3_cmp_ff <= s2_cmp_ff;
         s4_cmp_ff <= s3_cmp_ff;
         lv_ff     <= cmd.leaf_mul;
         l_more_ff <= cmd.leaf_mul && cmd.leaf_more;
         ovf_ff    <= ovf_in;
         if (cmd.start) begin
            m_ff <= PW'(lowest_leaf_factor);
         end else if (lv_ff && l_more_ff) begin
            m_ff <= m_r[PW-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         spot_ff   <= spot_price;
         strike_ff <= strike;
         put_ff    <= is_put;
         p_ff      <= p_in;
         q_ff      <= blop_pkg::Q30_ONE - p_in;
      end
      if (cmd.ind_rd) begin
         s1_addr_ff <= cmd_addr - 1'b1;
      end
      if (s1_rd_ff) begin
         prev_ff <= rd_ff;
      end
      prod_a_ff  <= mul_a_x * mul_a_y;
      prod_b_ff  <= mul_b_x * mul_b_y;
      addr2_ff   <= cmd.leaf_mul ? cmd_addr : s1_addr_ff;
      mean_ff    <= acc[61:30];
      s3_addr_ff <= addr2_ff;
      prod_d_ff  <= mean_ff * PW'(step_discount);
      s4_addr_ff <= s3_addr_ff;
      // last write to node zero is the option price
      if (wr_en && (wr_addr == '0)) begin
         res_ff <= wr_data;
      end
      if (cmd.finish) begin
         out_price_ff <= res_ff;
         out_sat_ff   <= ovf_ff;
      end
   end

   assign option_price = out_price_ff;
   assign saturated    = out_sat_ff;

endmodule

// ----- hdl/binomial_lattice_option_pricer.sv -----
// Top level of the binomial lattice European option pricer.
// Prices one European call or put per request on an n-step binomial lattice
// held in a single node memory of MAX_STEPS+1 words. Prices are unsigned
// Q16.16, factors Q2.30, the up probability Q0.30 (clamped to one); every
// product rounds half up and saturates to all ones, which sets the saturated
// flag of the response. The leaves are built one at a time, n being step_count
// clamped to MAX_STEPS, because each leaf multiplier waits on the registered
// product of the one before; then the induction passes run one node update
// per cycle, set by the single memory read port, and passes of five nodes or
// fewer wait for the node pipeline to drain. Only one request is in work at
// a time; a new one is taken as soon as the previous result sits in the
// response register. The user must write registers only while the block is
// idle; the block itself does not enforce this. No memory clearing happens
// after reset.
module binomial_lattice_option_pricer #(
   parameter int MAX_STEPS = blop_pkg::MAX_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   blop_req_if.sink                        req_chan,
   blop_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [blop_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blop_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(MAX_STEPS + 1);

   // configuration registers
   logic [blop_pkg::STEP_W-1:0]   step_count_ff;
   logic [blop_pkg::FACTOR_W-1:0] up_sq_ff;
   logic [blop_pkg::COEF_W-1:0]   low_leaf_ff;
   logic [blop_pkg::COEF_W-1:0]   up_prob_ff;
   logic [blop_pkg::COEF_W-1:0]   discount_ff;

   blop_pkg::cmd_type cmd;
   blop_pkg::sts_type sts;
   logic [AW-1:0]     cmd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= blop_pkg::STEP_COUNT_RST;
         up_sq_ff      <= blop_pkg::UP_SQ_RST;
         low_leaf_ff   <= blop_pkg::LOW_LEAF_RST;
         up_prob_ff    <= blop_pkg::UP_PROB_RST;
         discount_ff   <= blop_pkg::DISCOUNT_RST;
      end else if (csr_wr_en) begin
         case (blop_pkg::csr_index_type'(csr_index))
            blop_pkg::CSR_STEP_COUNT: begin
               step_count_ff <= csr_wdata[blop_pkg::STEP_W-1:0];
            end
            blop_pkg::CSR_UP_SQUARED: begin
               up_sq_ff <= csr_wdata[blop_pkg::FACTOR_W-1:0];
            end
            blop_pkg::CSR_LOWEST_LEAF: begin
               low_leaf_ff <= csr_wdata[blop_pkg::COEF_W-1:0];
            end
            blop_pkg::CSR_UP_PROB: begin
               up_prob_ff <= csr_wdata[blop_pkg::COEF_W-1:0];
            end
            blop_pkg::CSR_STEP_DISCOUNT: begin
               discount_ff <= csr_wdata[blop_pkg::COEF_W-1:0];
            end
            default: begin
               // unknown index: write ignored
            end
         endcase
      end
   end

   blop_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .step_count (step_count_ff),
      .cmd        (cmd),
      .cmd_addr   (cmd_addr),
      .sts        (sts)
   );

   blop_dp #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .cmd_addr           (cmd_addr),
      .sts                (sts),
      .spot_price         (req_chan.spot_price),
      .strike             (req_chan.strike),
      .is_put             (req_chan.is_put),
      .up_factor_squared  (up_sq_ff),
      .lowest_leaf_factor (low_leaf_ff),
      .up_probability     (up_prob_ff),
      .step_discount      (discount_ff),
      .option_price       (rsp_chan.option_price),
      .saturated          (rsp_chan.saturated)
   );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench of the binomial lattice European option pricer.
module tb_top;

   // Deepest lattice the block builds; step counts above it are clamped.
   localparam int          LATTICE_MAX = blop_pkg::MAX_STEPS_DEF;
   // Cycles without any accepted request or response before giving up.
   localparam int          STALL_LIMIT = 2_000_000;
   localparam logic [31:0] Q30_UNIT    = 32'h4000_0000;
   localparam logic [63:0] Q30_ROUND   = 64'h0000_0000_2000_0000;

   typedef struct {
      bit [31:0] price;
      bit        sat;
   } option_quote_type;

   logic clock;
   logic reset;
   logic                            csr_wr_en;
   logic [blop_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [blop_pkg::CSR_DATA_W-1:0] csr_wdata;

   blop_req_if req_bus ();
   blop_rsp_if rsp_bus ();

   binomial_lattice_option_pricer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the lattice registers, at the widths the block keeps.
   bit [10:0] cfg_steps;
   bit [31:0] cfg_up_squared;
   bit [30:0] cfg_lowest_leaf;
   bit [30:0] cfg_up_prob;
   bit [30:0] cfg_discount;

   // Node array of the predictor, one word per lattice node.
   bit [31:0] lattice_nodes [0:LATTICE_MAX];

   // Quotes still owed by the block, oldest first.
   option_quote_type expected_quotes [$];

   int mismatch_count = 0;
   bit idling_on      = 1'b1;
   int rsp_hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Q2.30 product, rounded half up; saturates to all ones and sets ovf.
   function automatic bit [31:0] q30_scale(input bit [31:0] a, input bit [31:0] b,
                                           inout bit ovf);
      bit [63:0] prod;
      prod = 64'(a) * 64'(b) + Q30_ROUND;
      if (prod[63:62] != 2'b00) begin
         ovf = 1'b1;
         return 32'hFFFF_FFFF;
      end
      return prod[61:30];
   endfunction

   // Prices one request against the current register copy: payoff at every
   // leaf, then backward induction in place over the node array.
   function automatic option_quote_type price_option(input bit [31:0] spot,
                                                     input bit [31:0] strike,
                                                     input bit put);
      option_quote_type quote;
      int unsigned   steps;
      int unsigned   j;
      int unsigned   s;
      bit [31:0]     up_p;
      bit [31:0]     down_p;
      bit [31:0]     mult;
      bit [31:0]     leaf_price;
      bit [63:0]     acc;
      bit            ovf;
      steps = (cfg_steps > LATTICE_MAX) ? LATTICE_MAX : cfg_steps;
      up_p = (32'(cfg_up_prob) > Q30_UNIT) ? Q30_UNIT : 32'(cfg_up_prob);
      down_p = Q30_UNIT - up_p;
      ovf = 1'b0;
      mult = 32'(cfg_lowest_leaf);
      for (j = 0; j <= steps; j++) begin
         leaf_price = q30_scale(spot, mult, ovf);
         if (put) begin
            lattice_nodes[j] = (strike > leaf_price) ? strike - leaf_price : 32'd0;
         end else begin
            lattice_nodes[j] = (leaf_price > strike) ? leaf_price - strike : 32'd0;
         end
         if (j < steps) begin
            mult = q30_scale(mult, cfg_up_squared, ovf);
         end
      end
      for (s = steps; s > 0; s--) begin
         for (j = 0; j < s; j++) begin
            // weights sum to one, so the mean always fits 32 bits
            acc = 64'(up_p) * 64'(lattice_nodes[j + 1])
                + 64'(down_p) * 64'(lattice_nodes[j]) + Q30_ROUND;
            lattice_nodes[j] = q30_scale(acc[61:30], 32'(cfg_discount), ovf);
         end
      end
      quote.price = lattice_nodes[0];
      quote.sat   = ovf;
      return quote;
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // One register write; the local copy is masked as the block masks it.
   task automatic write_register(input blop_pkg::csr_index_type idx,
                                 input bit [31:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         blop_pkg::CSR_STEP_COUNT:    cfg_steps       = value[10:0];
         blop_pkg::CSR_UP_SQUARED:    cfg_up_squared  = value;
         blop_pkg::CSR_LOWEST_LEAF:   cfg_lowest_leaf = value[30:0];
         blop_pkg::CSR_UP_PROB:       cfg_up_prob     = value[30:0];
         blop_pkg::CSR_STEP_DISCOUNT: cfg_discount    = value[30:0];
         default: ;
      endcase
   endtask

   task automatic configure_lattice(input bit [31:0] steps, input bit [31:0] up_sq,
                                    input bit [31:0] low_leaf, input bit [31:0] up_prob,
                                    input bit [31:0] discount);
      write_register(blop_pkg::CSR_STEP_COUNT, steps);
      write_register(blop_pkg::CSR_UP_SQUARED, up_sq);
      write_register(blop_pkg::CSR_LOWEST_LEAF, low_leaf);
      write_register(blop_pkg::CSR_UP_PROB, up_prob);
      write_register(blop_pkg::CSR_STEP_DISCOUNT, discount);
   endtask

   // Offers one request, with an occasional idle burst first, and books the
   // predicted quote at the edge where it is taken.
   task automatic send_request(input bit [31:0] spot, input bit [31:0] strike,
                               input bit put);
      int gap;
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         gap = $urandom_range(1, 3);
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.spot_price = spot;
      req_bus.strike     = strike;
      req_bus.is_put     = put;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      expected_quotes.push_back(price_option(spot, strike, put));
   endtask

   // Drops valid and waits until every booked quote has come back, so the
   // block is idle and registers may be rewritten.
   task automatic wait_for_quotes();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_quotes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Plausible market: u^2 a little above one, lowest leaf near u^-n,
   // p near one half, discount just under one. Spare upper bits get noise.
   task automatic pick_market_setting(input int unsigned max_steps);
      int unsigned n;
      bit [31:0]   up_sq;
      real         u;
      real         f;
      n     = $urandom_range(0, max_steps);
      up_sq = Q30_UNIT + $urandom_range(0, 32'h0400_0000);
      u     = $sqrt(real'(up_sq) / 1073741824.0);
      f     = 1073741824.0;
      repeat (n) f = f / u;
      configure_lattice({21'($urandom), 11'(n)}, up_sq,
                        {1'($urandom), 31'(int'(f))},
                        {1'($urandom), 31'($urandom_range(32'h1C00_0000, 32'h2400_0000))},
                        {1'($urandom), 31'(Q30_UNIT - $urandom_range(0, 32'h0010_0000))});
   endtask

   // Anything goes in the factors; only the lattice depth is kept cheap.
   task automatic pick_noise_setting();
      configure_lattice({21'($urandom), 11'($urandom_range(0, 24))},
                        $urandom, $urandom, $urandom, $urandom);
   endtask

   // Strike within half the spot either way most of the time, else raw bits.
   task automatic send_random_request();
      bit [31:0] spot;
      bit [31:0] strike;
      if ($urandom_range(0, 3) == 0) begin
         spot   = $urandom;
         strike = $urandom;
      end else begin
         spot   = $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
         strike = (spot >> 1) + 32'($urandom_range(0, spot));
      end
      send_request(spot, strike, 1'($urandom_range(0, 1)));
   endtask

   // Response ready: long hold-off when asked, else random idle bursts.
   initial begin
      int burst;
      burst = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else if (burst > 0) begin
            rsp_bus.ready = 1'b0;
            burst--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            burst = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker and watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      option_quote_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_quotes.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected quote: price %h sat %b",
                        rsp_bus.option_price, rsp_bus.saturated);
            end
            mismatch_count++;
         end else begin
            want = expected_quotes.pop_front();
            if (rsp_bus.option_price !== want.price || rsp_bus.saturated !== want.sat) begin
               if (mismatch_count < 10) begin
                  $display("quote mismatch: expected price %h sat %b, got price %h sat %b",
                           want.price, want.sat, rsp_bus.option_price, rsp_bus.saturated);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("binomial_lattice_option_pricer test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset settings: one step, flat factors, even odds, no discounting.
   // Field extremes for both calls and puts.
   task automatic test_reset_defaults();
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(32'h0000_0000, 32'h0000_0000, 1'b0);
      wait_for_quotes();
   endtask

   // Zero steps: one leaf, no induction, price is the payoff at the leaf.
   task automatic test_single_leaf();
      configure_lattice(32'd0, Q30_UNIT, 32'h2000_0000, 32'h2000_0000, Q30_UNIT);
      send_request(32'd200 << 16, 32'd50 << 16, 1'b0);
      send_request(32'd200 << 16, 32'd150 << 16, 1'b1);
      send_request(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      wait_for_quotes();
   endtask

   // Probability above one is clamped; a discount near two grows the nodes
   // until they saturate.
   task automatic test_growth_saturation();
      configure_lattice(32'd3, Q30_UNIT, Q30_UNIT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(32'h4000_0000, 32'h0000_0000, 1'b0);
      send_request(32'd1000 << 16, 32'd10 << 16, 1'b0);
      send_request(32'd10 << 16, 32'd1000 << 16, 1'b1);
      wait_for_quotes();
   endtask

   // Widest factors: leaf prices saturate, puts see the saturated price.
   task automatic test_saturated_leaf_put();
      configure_lattice(32'd2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h2000_0000, Q30_UNIT);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(32'h1000_0000, 32'hFFFF_FFFF, 1'b1);
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      wait_for_quotes();
   endtask

   // Register extremes: zero leaf factor, probability and discount, then
   // everything at one with the largest up factor.
   task automatic test_factor_extremes();
      configure_lattice(32'd1, Q30_UNIT, 32'd0, 32'd0, 32'd0);
      send_request(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_request(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
      wait_for_quotes();
      configure_lattice(32'd2, 32'hFFFF_FFFF, Q30_UNIT, Q30_UNIT, Q30_UNIT);
      send_request(32'd3 << 16, 32'd1 << 16, 1'b0);
      send_request(32'd3 << 16, 32'd100 << 16, 1'b1);
      wait_for_quotes();
   endtask

   // Step count beyond the maximum clamps to the full 1024-step lattice;
   // factors for 20% volatility over one year, at-the-money call.
   task automatic test_deepest_lattice();
      configure_lattice(32'd2047, 32'd1087247778, 32'd1784129, 32'd541000000,
                        32'd1073689395);
      send_request(32'd100 << 16, 32'd100 << 16, 1'b0);
      wait_for_quotes();
   endtask

   // Responses held off for a long stretch while requests keep coming, so
   // the block fills up and stops taking requests.
   task automatic test_response_backpressure();
      pick_market_setting(4);
      rsp_hold_cycles = 300;
      repeat (6) send_random_request();
      wait_for_quotes();
   endtask

   // Phases of random settings, mostly plausible markets, every fourth noise.
   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         if (phase % 4 == 3) begin
            pick_noise_setting();
         end else begin
            pick_market_setting((phase == 6) ? 64 : 16);
         end
         repeat (8) send_random_request();
         wait_for_quotes();
      end
   endtask

   // Final stretch back to back, no idling on either side.
   task automatic test_steady_stream();
      idling_on = 1'b0;
      pick_market_setting(8);
      repeat (12) send_random_request();
      wait_for_quotes();
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = blop_pkg::CSR_STEP_COUNT;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.spot_price = '0;
      req_bus.strike     = '0;
      req_bus.is_put     = 1'b0;
      cfg_steps          = blop_pkg::STEP_COUNT_RST;
      cfg_up_squared     = blop_pkg::UP_SQ_RST;
      cfg_lowest_leaf    = blop_pkg::LOW_LEAF_RST;
      cfg_up_prob        = blop_pkg::UP_PROB_RST;
      cfg_discount       = blop_pkg::DISCOUNT_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_single_leaf();
      test_growth_saturation();
      test_saturated_leaf_put();
      test_factor_extremes();
      test_deepest_lattice();
      test_response_backpressure();
      test_random_settings();
      test_steady_stream();

      // drain is done; leave room for any stray extra response
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("binomial_lattice_option_pricer test passed");
      end else begin
         $display("binomial_lattice_option_pricer test failed");
      end
      $finish;
   end

endmodule
